// ===== src/dlr_pkg.sv =====
// Shared types and constants for the styled DDA line rasterizer.
`default_nettype none

package dlr_pkg;

   localparam int COORD_BITS = 12;
   localparam int LEN_BITS   = COORD_BITS + 1;
   localparam int STYLE_BITS = 2;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // dash pattern periods, centre-line thresholds and the residue at the first step
   localparam int DOT_PERIOD    = 25;
   localparam int DASH_PERIOD   = 15;
   localparam int CENTRE_PERIOD = 20;
   localparam int CENTRE_ON     = 10;
   localparam int CENTRE_DOT    = 15;
   localparam int FIRST_STEP_N  = 2;

   typedef enum logic [STYLE_BITS-1:0] {
      STYLE_SOLID  = 2'd0,
      STYLE_DOTTED = 2'd1,
      STYLE_DASHED = 2'd2,
      STYLE_CENTRE = 2'd3
   } style_type;

   typedef struct packed {
      logic                         opcode;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pixel_x;
      logic signed [COORD_BITS-1:0] pixel_y;
      logic                         draw;
      logic                         last_point;
      logic                         point_valid;
   } rsp_type;

   typedef struct packed {
      logic      restart;
      logic      advance;
      style_type style;
   } style_ctl_type;

endpackage

`default_nettype wire

// ===== src/dlr_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, for the step increments.
`default_nettype none

module dlr_div #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [dlr_pkg::LEN_BITS-1:0]  num,
   input  wire logic [dlr_pkg::LEN_BITS-1:0]  den,
   output logic                               done,
   output logic [FRAC_BITS:0]                 quot
);
   import dlr_pkg::*;

   localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

   logic [LEN_BITS:0]   rem_ff, rem_in;
   logic [LEN_BITS-1:0] den_ff, den_in;
   logic [FRAC_BITS:0]  quot_ff, quot_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic                ge;
   logic [LEN_BITS:0]   diff;
   logic [LEN_BITS:0]   rem_sel;

   assign ge      = rem_ff >= {1'b0, den_ff};
   assign diff    = rem_ff - {1'b0, den_ff};
   assign rem_sel = ge ? diff : rem_ff;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, num};
         den_in  = den;
         quot_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = {rem_sel[LEN_BITS-1:0], 1'b0};
         quot_in = {quot_ff[FRAC_BITS-1:0], ge};
         cnt_in  = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(FRAC_BITS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

// ===== src/dlr_style.sv =====
// Dash pattern tracker: running step residues and the draw decision per style.
`default_nettype none

module dlr_style (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dlr_pkg::style_ctl_type ctl,
   output logic                        draw
);
   import dlr_pkg::*;

   localparam int DOT_W    = $clog2(DOT_PERIOD);
   localparam int DASH_W   = $clog2(DASH_PERIOD);
   localparam int CENTRE_W = $clog2(CENTRE_PERIOD);

   logic [DOT_W-1:0]    dot_ff, dot_in;
   logic [DASH_W-1:0]   dash_ff, dash_in;
   logic [CENTRE_W-1:0] ctr_ff, ctr_in;
   logic                even_ff, even_in;

   always_comb begin
      dot_in  = dot_ff;
      dash_in = dash_ff;
      ctr_in  = ctr_ff;
      even_in = even_ff;
      if (ctl.restart) begin
         dot_in  = DOT_W'(FIRST_STEP_N);
         dash_in = DASH_W'(FIRST_STEP_N);
         ctr_in  = CENTRE_W'(FIRST_STEP_N);
         even_in = 1'b1;
      end else if (ctl.advance) begin
         dot_in  = (dot_ff == DOT_W'(DOT_PERIOD - 1)) ? '0 : dot_ff + DOT_W'(1);
         dash_in = (dash_ff == DASH_W'(DASH_PERIOD - 1)) ? '0 : dash_ff + DASH_W'(1);
         ctr_in  = (ctr_ff == CENTRE_W'(CENTRE_PERIOD - 1)) ? '0 : ctr_ff + CENTRE_W'(1);
         even_in = ~even_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff  <= DOT_W'(FIRST_STEP_N);
         dash_ff <= DASH_W'(FIRST_STEP_N);
         ctr_ff  <= CENTRE_W'(FIRST_STEP_N);
         even_ff <= 1'b1;
      end else begin
         dot_ff  <= dot_in;
         dash_ff <= dash_in;
         ctr_ff  <= ctr_in;
         even_ff <= even_in;
      end
   end

   always_comb begin
      case (ctl.style)
         STYLE_SOLID:  draw = 1'b1;
         STYLE_DOTTED: draw = (dot_ff == '0);
         STYLE_DASHED: draw = even_ff && (dash_ff != '0);
         STYLE_CENTRE: draw = ctr_ff inside {[0:CENTRE_ON], CENTRE_DOT};
         default:      draw = 1'b1;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/dda_line_rasterizer_styled_top.sv =====
// Top level of the styled DDA line rasterizer: sequencer, accumulators, output register.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  dlr_pkg::req_type
//   rsp_      out        rsp_valid/rsp_stall  dlr_pkg::rsp_type
//   csr_      in         csr_wr_en            line_style, 2 bits
//
// Step item: its point is registered the next cycle after it is accepted.
// Start item: first point registered the next cycle; for a nonzero length the two
//   increments are computed, x then y, in the shared bit-serial divider, req_stall high.
// Reset is synchronous; after it no line is active and the style is solid.
// req_stall is also high while the output register holds a stalled item.
`default_nettype none

module dda_line_rasterizer_styled_top #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire dlr_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output dlr_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_wr_en,
   input  wire logic [dlr_pkg::STYLE_BITS-1:0]      csr_wr_data
);
   import dlr_pkg::*;

   localparam int ACC_BITS = 1 + COORD_BITS + FRAC_BITS;
   localparam int INC_BITS = FRAC_BITS + 2;
   localparam logic signed [ACC_BITS-1:0] HALF_FIX = ACC_BITS'(1) <<< (FRAC_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DIV_X = 3'b010,
      ST_DIV_Y = 3'b100
   } state_type;

   state_type                    state_ff, state_in;
   logic signed [ACC_BITS-1:0]   x_acc_ff, x_acc_in, y_acc_ff, y_acc_in;
   logic signed [INC_BITS-1:0]   x_inc_ff, x_inc_in, y_inc_ff, y_inc_in;
   logic [LEN_BITS-1:0]          step_cnt_ff, step_cnt_in;
   logic [LEN_BITS-1:0]          line_len_ff, line_len_in;
   logic                         active_ff, active_in;
   logic [LEN_BITS-1:0]          y_mag_ff, y_mag_in;
   logic                         x_neg_ff, x_neg_in, y_neg_ff, y_neg_in;
   style_type                    style_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_data_ff, rsp_data_in;

   logic                         req_fire, rsp_fire, is_start;
   logic signed [LEN_BITS-1:0]   dx, dy;
   logic [LEN_BITS-1:0]          x_mag, y_mag, len;
   logic signed [ACC_BITS-1:0]   x_start, y_start, x_sum, y_sum;
   logic [LEN_BITS-1:0]          step_next;
   logic                         div_start, div_done;
   logic [LEN_BITS-1:0]          div_num, div_den;
   logic [FRAC_BITS:0]           div_quot;
   logic signed [INC_BITS-1:0]   quot_ext, quot_neg;
   style_ctl_type                style_ctl;
   logic                         style_draw;

   function automatic logic signed [COORD_BITS-1:0] to_pixel(
      input logic signed [ACC_BITS-1:0] acc
   );
      logic signed [COORD_BITS:0]   int_part;
      logic                         round_up;
      logic signed [COORD_BITS+1:0] p;
      logic                         fits;
      int_part = acc[ACC_BITS-1:FRAC_BITS];
      round_up = acc[ACC_BITS-1] && (|acc[FRAC_BITS-1:0]);
      p        = {int_part[COORD_BITS], int_part} + (COORD_BITS+2)'(round_up);
      fits     = (p[COORD_BITS+1] == p[COORD_BITS]) && (p[COORD_BITS] == p[COORD_BITS-1]);
      if (fits)
         return p[COORD_BITS-1:0];
      else if (p[COORD_BITS+1])
         return {1'b1, {(COORD_BITS-1){1'b0}}};
      else
         return {1'b0, {(COORD_BITS-1){1'b1}}};
   endfunction

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;
   assign is_start  = (req_data.opcode == OP_START);

   // start item geometry
   assign dx    = $signed({req_data.end_x[COORD_BITS-1], req_data.end_x})
                - $signed({req_data.start_x[COORD_BITS-1], req_data.start_x});
   assign dy    = $signed({req_data.end_y[COORD_BITS-1], req_data.end_y})
                - $signed({req_data.start_y[COORD_BITS-1], req_data.start_y});
   assign x_mag = dx[LEN_BITS-1] ? LEN_BITS'(-dx) : LEN_BITS'(dx);
   assign y_mag = dy[LEN_BITS-1] ? LEN_BITS'(-dy) : LEN_BITS'(dy);
   assign len   = (x_mag >= y_mag) ? x_mag : y_mag;

   always_comb begin
      x_start = $signed({req_data.start_x[COORD_BITS-1], req_data.start_x,
                         {FRAC_BITS{1'b0}}});
      y_start = $signed({req_data.start_y[COORD_BITS-1], req_data.start_y,
                         {FRAC_BITS{1'b0}}});
      if (dx[LEN_BITS-1])
         x_start = x_start - HALF_FIX;
      else if (dx != '0)
         x_start = x_start + HALF_FIX;
      if (dy[LEN_BITS-1])
         y_start = y_start - HALF_FIX;
      else if (dy != '0)
         y_start = y_start + HALF_FIX;
   end

   assign x_sum     = x_acc_ff + ACC_BITS'(x_inc_ff);
   assign y_sum     = y_acc_ff + ACC_BITS'(y_inc_ff);
   assign step_next = step_cnt_ff + LEN_BITS'(1);

   // shared divider: x axis at start, y axis once x is done
   assign div_start = (req_fire && is_start && (len != '0))
                   || ((state_ff == ST_DIV_X) && div_done);
   assign div_num   = (state_ff == ST_DIV_X) ? y_mag_ff : x_mag;
   assign div_den   = (state_ff == ST_DIV_X) ? line_len_ff : len;
   assign quot_ext  = $signed({1'b0, div_quot});
   assign quot_neg  = -quot_ext;

   dlr_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign style_ctl.restart = req_fire && is_start;
   assign style_ctl.advance = req_fire && !is_start && active_ff;
   assign style_ctl.style   = style_ff;

   dlr_style u_style (
      .clock (clock),
      .reset (reset),
      .ctl   (style_ctl),
      .draw  (style_draw)
   );

   always_comb begin
      state_in     = state_ff;
      x_acc_in     = x_acc_ff;
      y_acc_in     = y_acc_ff;
      x_inc_in     = x_inc_ff;
      y_inc_in     = y_inc_ff;
      step_cnt_in  = step_cnt_ff;
      line_len_in  = line_len_ff;
      active_in    = active_ff;
      y_mag_in     = y_mag_ff;
      x_neg_in     = x_neg_ff;
      y_neg_in     = y_neg_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in = 1'b1;
               if (is_start) begin
                  x_acc_in    = x_start;
                  y_acc_in    = y_start;
                  x_inc_in    = '0;
                  y_inc_in    = '0;
                  step_cnt_in = '0;
                  line_len_in = len;
                  active_in   = (len != '0);
                  y_mag_in    = y_mag;
                  x_neg_in    = dx[LEN_BITS-1];
                  y_neg_in    = dy[LEN_BITS-1];
                  rsp_data_in.pixel_x     = to_pixel(x_start);
                  rsp_data_in.pixel_y     = to_pixel(y_start);
                  rsp_data_in.draw        = 1'b1;
                  rsp_data_in.last_point  = (len == '0);
                  rsp_data_in.point_valid = 1'b1;
                  if (len != '0)
                     state_in = ST_DIV_X;
               end else if (active_ff) begin
                  x_acc_in    = x_sum;
                  y_acc_in    = y_sum;
                  step_cnt_in = step_next;
                  active_in   = (step_next < line_len_ff);
                  rsp_data_in.pixel_x     = to_pixel(x_sum);
                  rsp_data_in.pixel_y     = to_pixel(y_sum);
                  rsp_data_in.draw        = style_draw;
                  rsp_data_in.last_point  = (step_next >= line_len_ff);
                  rsp_data_in.point_valid = 1'b1;
               end else begin
                  rsp_data_in = '0;
               end
            end
         end
         ST_DIV_X: begin
            if (div_done) begin
               x_inc_in = x_neg_ff ? quot_neg : quot_ext;
               state_in = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_done) begin
               y_inc_in = y_neg_ff ? quot_neg : quot_ext;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_acc_ff    <= x_acc_in;
      y_acc_ff    <= y_acc_in;
      x_inc_ff    <= x_inc_in;
      y_inc_ff    <= y_inc_in;
      step_cnt_ff <= step_cnt_in;
      line_len_ff <= line_len_in;
      y_mag_ff    <= y_mag_in;
      x_neg_ff    <= x_neg_in;
      y_neg_ff    <= y_neg_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         style_ff     <= STYLE_SOLID;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en)
            style_ff <= style_type'(csr_wr_data);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== src/dlr_checker.sv =====
// Port-level checks for the styled DDA line rasterizer, bound to the top level.
`default_nettype none

module dlr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire dlr_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire dlr_pkg::rsp_type rsp_data
);
   import dlr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp item changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_item_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item gave no rsp item");

   a_start_point: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.opcode == OP_START)
      |=> rsp_data.point_valid && rsp_data.draw)
      else $error("first point not valid and drawn");

   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.point_valid
      |-> !rsp_data.draw && !rsp_data.last_point
          && (rsp_data.pixel_x == '0) && (rsp_data.pixel_y == '0))
      else $error("step without line gave nonzero fields");

endmodule

bind dda_line_rasterizer_styled_top dlr_checker u_dlr_checker (.*);

`default_nettype wire
